// File: src/rlb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlb_pkg
// Shared types and codes for the reference list builder.
// ----------------------------------------------------------------------------
package rlb_pkg;

  localparam int NUM_LISTS   = 3;
  localparam int QUEUE_DEPTH = 2;

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam logic [7:0] NO_SLOT = 8'hFF;

  typedef enum logic [1:0] {
    LST_BEFORE = 2'd0,
    LST_AFTER  = 2'd1,
    LST_LONG   = 2'd2
  } list_id_t;

  typedef enum logic {
    OP_ADD    = 1'b0,
    OP_FINISH = 1'b1
  } op_t;

  // one classified item as it travels from front to back
  typedef struct packed {
    op_t                op;
    list_id_t           lst;
    logic [7:0]         slot;
    logic signed [31:0] order;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_INSERT,
    BK_EMIT
  } back_state_t;

endpackage
`default_nettype wire

// File: src/hevc_reference_list_builder_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Timing: an add is committed in the cycle after the back end pops it from the queue;
// a finish passes the queue, back-end state and output register before its first result;
// the back end takes no new add until the compare then insert steps of the last are done;
// on finish, 3 * LIST_SIZE results leave the output register at one per cycle while popped.
// Reset: synchronous active-low rst_n empties the queue and output and zeroes list counts.
// ----------------------------------------------------------------------------
// hevc_reference_list_builder_top
// Builds short-term before/after and long-term reference lists, emitted on finish.
// ----------------------------------------------------------------------------
module hevc_reference_list_builder_top #(
  parameter int LIST_SIZE = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire logic               in_cmd,
  input  wire logic               in_short_before,
  input  wire logic               in_short_after,
  input  wire logic               in_long_term,
  input  wire logic [7:0]         in_ref_slot,
  input  wire logic signed [31:0] in_ref_order,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output logic [1:0]              out_list_id,
  output logic [2:0]              out_position,
  output logic [7:0]              out_slot,
  output logic [3:0]              out_count_before,
  output logic [3:0]              out_count_after,
  output logic [3:0]              out_count_long,
  output logic                    out_last
);
  import rlb_pkg::*;

  job_t front_job;
  logic front_keep;
  logic q_valid;
  logic q_ready;
  job_t q_data;
  logic out_valid;

  rlb_front u_front (
    .in_cmd          (in_cmd),
    .in_short_before (in_short_before),
    .in_short_after  (in_short_after),
    .in_long_term    (in_long_term),
    .in_ref_slot     (in_ref_slot),
    .in_ref_order    (in_ref_order),
    .job             (front_job),
    .keep            (front_keep)
  );

  rlb_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (in_push && front_keep),
    .wr_data  (front_job),
    .full     (in_full),
    .rd_valid (q_valid),
    .rd_en    (q_ready),
    .rd_data  (q_data)
  );

  rlb_back #(
    .LIST_SIZE (LIST_SIZE)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_data           (q_data),
    .q_ready          (q_ready),
    .out_valid        (out_valid),
    .out_pop          (out_pop),
    .out_list_id      (out_list_id),
    .out_position     (out_position),
    .out_slot         (out_slot),
    .out_count_before (out_count_before),
    .out_count_after  (out_count_after),
    .out_count_long   (out_count_long),
    .out_last         (out_last)
  );

  assign out_empty = !out_valid;

endmodule
`default_nettype wire

// File: src/rlb_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlb_front
// Classifies an incoming item: picks the target list by priority, or marks
// a finish; adds with no category bit are not forwarded.
// ----------------------------------------------------------------------------
module rlb_front (
  input  wire logic               in_cmd,
  input  wire logic               in_short_before,
  input  wire logic               in_short_after,
  input  wire logic               in_long_term,
  input  wire logic [7:0]         in_ref_slot,
  input  wire logic signed [31:0] in_ref_order,
  output rlb_pkg::job_t           job,
  output logic                    keep
);
  import rlb_pkg::*;

  always_comb begin
    job.op    = (in_cmd == CMD_ADD) ? OP_ADD : OP_FINISH;
    job.slot  = in_ref_slot;
    job.order = in_ref_order;
    keep      = 1'b1;
    if (in_short_before) begin
      job.lst = LST_BEFORE;
    end else if (in_short_after) begin
      job.lst = LST_AFTER;
    end else begin
      job.lst = LST_LONG;
      // add with no category bit is ignored
      if (!in_long_term && in_cmd == CMD_ADD) begin
        keep = 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// File: src/rlb_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlb_fifo
// Short queue of classified items between front and back.
// ----------------------------------------------------------------------------
module rlb_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_en,
  input  wire rlb_pkg::job_t wr_data,
  output logic               full,
  output logic               rd_valid,
  input  wire logic          rd_en,
  output rlb_pkg::job_t      rd_data
);
  import rlb_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  job_t          mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_wr, do_rd;

  assign full     = (cnt_r == CW'(QUEUE_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

// File: src/rlb_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlb_back
// Holds the three lists, does sorted insert with duplicate check, and
// streams the lists out on finish through an output register.
// ----------------------------------------------------------------------------
module rlb_back #(
  parameter int LIST_SIZE = 8
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_valid,
  input  wire rlb_pkg::job_t  q_data,
  output logic                q_ready,
  output logic                out_valid,
  input  wire logic           out_pop,
  output logic [1:0]          out_list_id,
  output logic [2:0]          out_position,
  output logic [7:0]          out_slot,
  output logic [3:0]          out_count_before,
  output logic [3:0]          out_count_after,
  output logic [3:0]          out_count_long,
  output logic                out_last
);
  import rlb_pkg::*;

  localparam int IW = (LIST_SIZE > 1) ? $clog2(LIST_SIZE) : 1;
  localparam int CW = $clog2(LIST_SIZE + 1);
  localparam logic [IW-1:0] LAST_POS = IW'(LIST_SIZE - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(LIST_SIZE);

  logic [7:0]         slots_r  [NUM_LISTS][LIST_SIZE];
  logic signed [31:0] orders_r [NUM_LISTS][LIST_SIZE];
  logic [CW-1:0]      cnt_r    [NUM_LISTS];
  logic [CW-1:0]      cnt_nxt  [NUM_LISTS];

  back_state_t   state_r, state_nxt;
  job_t          job_r, job_nxt;
  logic [IW-1:0] pos_r, pos_nxt;
  logic          skip_r, skip_nxt;
  list_id_t      elst_r, elst_nxt;
  logic [IW-1:0] epos_r, epos_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_list_id_r, out_list_id_nxt;
  logic [2:0]    out_position_r, out_position_nxt;
  logic [7:0]    out_slot_r, out_slot_nxt;
  logic [3:0]    out_cb_r, out_cb_nxt;
  logic [3:0]    out_ca_r, out_ca_nxt;
  logic [3:0]    out_cl_r, out_cl_nxt;
  logic          out_last_r, out_last_nxt;

  // compare the queue head against its list
  logic [CW-1:0] head_n;
  logic          head_dup;
  logic [IW-1:0] head_pos;
  logic          emit_last;

  always_comb begin
    head_n   = cnt_r[q_data.lst];
    head_dup = 1'b0;
    head_pos = IW'(head_n);
    for (int i = LIST_SIZE - 1; i >= 0; i--) begin
      if (CW'(i) < head_n) begin
        if (slots_r[q_data.lst][i] == q_data.slot) begin
          head_dup = 1'b1;
        end
        case (q_data.lst)
          LST_BEFORE: if (q_data.order > orders_r[q_data.lst][i]) head_pos = IW'(i);
          LST_AFTER:  if (q_data.order < orders_r[q_data.lst][i]) head_pos = IW'(i);
          default:    ;
        endcase
      end
    end
  end

  assign emit_last = (elst_r == LST_LONG) && (epos_r == LAST_POS);

  always_comb begin
    state_nxt        = state_r;
    job_nxt          = job_r;
    pos_nxt          = pos_r;
    skip_nxt         = skip_r;
    elst_nxt         = elst_r;
    epos_nxt         = epos_r;
    cnt_nxt          = cnt_r;
    q_ready          = 1'b0;
    out_valid_nxt    = out_valid_r && !out_pop;
    out_list_id_nxt  = out_list_id_r;
    out_position_nxt = out_position_r;
    out_slot_nxt     = out_slot_r;
    out_cb_nxt       = out_cb_r;
    out_ca_nxt       = out_ca_r;
    out_cl_nxt       = out_cl_r;
    out_last_nxt     = out_last_r;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_ready = 1'b1;
          if (q_data.op == OP_ADD) begin
            job_nxt   = q_data;
            pos_nxt   = head_pos;
            skip_nxt  = head_dup || (head_n == FULL_CNT);
            state_nxt = BK_INSERT;
          end else begin
            elst_nxt  = LST_BEFORE;
            epos_nxt  = '0;
            state_nxt = BK_EMIT;
          end
        end
      end
      BK_INSERT: begin
        if (!skip_r) begin
          cnt_nxt[job_r.lst] = cnt_r[job_r.lst] + 1'b1;
        end
        state_nxt = BK_IDLE;
      end
      BK_EMIT: begin
        if (!out_valid_r || out_pop) begin
          out_valid_nxt    = 1'b1;
          out_list_id_nxt  = elst_r;
          out_position_nxt = 3'(epos_r);
          out_slot_nxt     = (CW'(epos_r) < cnt_r[elst_r]) ?
                             slots_r[elst_r][epos_r] : NO_SLOT;
          out_cb_nxt       = 4'(cnt_r[LST_BEFORE]);
          out_ca_nxt       = 4'(cnt_r[LST_AFTER]);
          out_cl_nxt       = 4'(cnt_r[LST_LONG]);
          out_last_nxt     = emit_last;
          if (emit_last) begin
            for (int l = 0; l < NUM_LISTS; l++) begin
              cnt_nxt[l] = '0;
            end
            state_nxt = BK_IDLE;
          end else if (epos_r == LAST_POS) begin
            epos_nxt = '0;
            case (elst_r)
              LST_BEFORE: elst_nxt = LST_AFTER;
              default:    elst_nxt = LST_LONG;
            endcase
          end else begin
            epos_nxt = epos_r + 1'b1;
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
      for (int l = 0; l < NUM_LISTS; l++) begin
        cnt_r[l] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r          <= job_nxt;
    pos_r          <= pos_nxt;
    skip_r         <= skip_nxt;
    elst_r         <= elst_nxt;
    epos_r         <= epos_nxt;
    out_list_id_r  <= out_list_id_nxt;
    out_position_r <= out_position_nxt;
    out_slot_r     <= out_slot_nxt;
    out_cb_r       <= out_cb_nxt;
    out_ca_r       <= out_ca_nxt;
    out_cl_r       <= out_cl_nxt;
    out_last_r     <= out_last_nxt;
  end

  // sorted insert: shift the tail up by one, drop the new entry in
  always_ff @(posedge clk) begin
    if (state_r == BK_INSERT && !skip_r) begin
      for (int i = 0; i < LIST_SIZE; i++) begin
        if (IW'(i) == pos_r) begin
          slots_r[job_r.lst][i]  <= job_r.slot;
          orders_r[job_r.lst][i] <= job_r.order;
        end
      end
      for (int i = 1; i < LIST_SIZE; i++) begin
        if (IW'(i) > pos_r) begin
          slots_r[job_r.lst][i]  <= slots_r[job_r.lst][i-1];
          orders_r[job_r.lst][i] <= orders_r[job_r.lst][i-1];
        end
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_list_id      = out_list_id_r;
  assign out_position     = out_position_r;
  assign out_slot         = out_slot_r;
  assign out_count_before = out_cb_r;
  assign out_count_after  = out_ca_r;
  assign out_count_long   = out_cl_r;
  assign out_last         = out_last_r;

endmodule
`default_nettype wire

// File: src/rlb_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlb_checker
// Port-level checks on the result side of the reference list builder.
// ----------------------------------------------------------------------------
module rlb_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_empty,
  input wire logic       out_pop,
  input wire logic [1:0] out_list_id,
  input wire logic [7:0] out_slot,
  input wire logic [3:0] out_count_before,
  input wire logic [3:0] out_count_after,
  input wire logic [3:0] out_count_long,
  input wire logic       out_last
);
  import rlb_pkg::*;

  // nothing to deliver right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result shown right after reset");

  // the final item of a run belongs to the long-term list
  a_last_long: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_last) |-> (out_list_id == LST_LONG))
    else $error("last flag outside long-term list");

  // counts are a snapshot taken at finish and stay fixed for the whole run
  a_counts_fixed: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pop && !out_last) |=>
      (out_empty || (out_count_before == $past(out_count_before) &&
                     out_count_after  == $past(out_count_after) &&
                     out_count_long   == $past(out_count_long))))
    else $error("counts changed within a run");

  // a waiting result holds until it is taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_slot) && $stable(out_list_id)))
    else $error("waiting result changed");

endmodule

bind hevc_reference_list_builder_top rlb_checker u_rlb_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_empty        (out_empty),
  .out_pop          (out_pop),
  .out_list_id      (out_list_id),
  .out_slot         (out_slot),
  .out_count_before (out_count_before),
  .out_count_after  (out_count_after),
  .out_count_long   (out_count_long),
  .out_last         (out_last)
);
`default_nettype wire

// File: tb/sv/hevc_reference_list_builder_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hevc_reference_list_builder_top_tb
// Self-checking bench for the reference list builder. Pictures are filed into
// a local copy of the three lists as they are accepted. Each finish queues the
// full emitted run, and every popped result is checked against it. A directed
// opening covers the corner cases. Random pictures and finishes follow, with
// idle cycles on both sides.
// ----------------------------------------------------------------------------
module hevc_reference_list_builder_top_tb;
  import rlb_pkg::*;

  localparam int LIST_SIZE  = 8;
  localparam int RAND_ITEMS = 230;
  localparam int STALL_MAX  = 4000;
  localparam int DRAIN      = 16;

  typedef struct {
    op_t                op;
    logic               st_before;
    logic               after;
    logic               long_term;
    logic [7:0]         slot;
    logic signed [31:0] order;
  } ref_cmd_t;

  typedef struct packed {
    list_id_t   lst;
    logic [2:0] pos;
    logic [7:0] slot;
    logic [3:0] n_before;
    logic [3:0] n_after;
    logic [3:0] n_long;
    logic       last;
  } list_entry_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_push = 1'b0;
  logic               in_full;
  logic               in_cmd = CMD_ADD;
  logic               in_short_before = 1'b0;
  logic               in_short_after = 1'b0;
  logic               in_long_term = 1'b0;
  logic [7:0]         in_ref_slot = 8'd0;
  logic signed [31:0] in_ref_order = 32'sd0;
  logic               out_empty;
  logic               out_pop = 1'b0;
  logic [1:0]         out_list_id;
  logic [2:0]         out_position;
  logic [7:0]         out_slot;
  logic [3:0]         out_count_before;
  logic [3:0]         out_count_after;
  logic [3:0]         out_count_long;
  logic               out_last;

  hevc_reference_list_builder_top #(
    .LIST_SIZE(LIST_SIZE)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_cmd           (in_cmd),
    .in_short_before  (in_short_before),
    .in_short_after   (in_short_after),
    .in_long_term     (in_long_term),
    .in_ref_slot      (in_ref_slot),
    .in_ref_order     (in_ref_order),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_list_id      (out_list_id),
    .out_position     (out_position),
    .out_slot         (out_slot),
    .out_count_before (out_count_before),
    .out_count_after  (out_count_after),
    .out_count_long   (out_count_long),
    .out_last         (out_last)
  );

  always #6 clk = ~clk;

  ref_cmd_t    picture_cmds[$];
  list_entry_t list_entries_due[$];
  ref_cmd_t    cmd_on_bus;

  // local copy of the three lists
  logic [7:0]         list_slot  [NUM_LISTS][LIST_SIZE];
  logic signed [31:0] list_order [NUM_LISTS][LIST_SIZE];
  int                 list_fill  [NUM_LISTS];

  int  items_taken = 0;
  int  mismatches = 0;
  int  stall_cycles = 0;
  bit  calm;

  // no idling on either side over a stretch in the middle of the run
  assign calm = (items_taken >= 110) && (items_taken < 160);

  function automatic void queue_cmd(ref_cmd_t c);
    picture_cmds.insert(picture_cmds.size(), c);
  endfunction

  function automatic ref_cmd_t make_cmd(op_t op, logic b, logic a, logic l,
                                        logic [7:0] slot, logic signed [31:0] order);
    ref_cmd_t c;
    c.op        = op;
    c.st_before = b;
    c.after     = a;
    c.long_term = l;
    c.slot      = slot;
    c.order     = order;
    return c;
  endfunction

  function automatic logic signed [31:0] pick_order();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'sh8000_0000;
    if (r == 1) return 32'sh7FFF_FFFF;
    if (r < 6) return 32'(int'($urandom_range(0, 40)) - 20);
    return $urandom;
  endfunction

  function automatic logic [7:0] pick_slot();
    if ($urandom_range(0, 9) < 7) return 8'($urandom_range(0, 15));
    return 8'($urandom_range(0, 254));
  endfunction

  function automatic void file_reference(ref_cmd_t c);
    int lst;
    int n;
    int pos;
    if (c.st_before) lst = int'(LST_BEFORE);
    else if (c.after) lst = int'(LST_AFTER);
    else if (c.long_term) lst = int'(LST_LONG);
    else return;
    n = list_fill[lst];
    if (n >= LIST_SIZE) return;
    for (int i = 0; i < n; i++)
      if (list_slot[lst][i] == c.slot) return;
    pos = n;
    // before list descends, after list ascends, ties go behind
    for (int i = 0; i < n; i++) begin
      if ((lst == int'(LST_BEFORE) && c.order > list_order[lst][i]) ||
          (lst == int'(LST_AFTER) && c.order < list_order[lst][i])) begin
        pos = i;
        break;
      end
    end
    for (int i = n; i > pos; i--) begin
      list_slot[lst][i]  = list_slot[lst][i-1];
      list_order[lst][i] = list_order[lst][i-1];
    end
    list_slot[lst][pos]  = c.slot;
    list_order[lst][pos] = c.order;
    list_fill[lst]       = n + 1;
  endfunction

  function automatic void emit_lists();
    list_entry_t e;
    for (int l = 0; l < NUM_LISTS; l++) begin
      for (int p = 0; p < LIST_SIZE; p++) begin
        e.lst      = list_id_t'(l);
        e.pos      = 3'(p);
        e.slot     = (p < list_fill[l]) ? list_slot[l][p] : NO_SLOT;
        e.n_before = 4'(list_fill[0]);
        e.n_after  = 4'(list_fill[1]);
        e.n_long   = 4'(list_fill[2]);
        e.last     = (l == NUM_LISTS - 1) && (p == LIST_SIZE - 1);
        list_entries_due.insert(list_entries_due.size(), e);
      end
    end
    for (int l = 0; l < NUM_LISTS; l++) list_fill[l] = 0;
  endfunction

  function automatic string show_entry(list_entry_t e);
    return $sformatf("list %0d pos %0d slot %0d counts %0d/%0d/%0d last %0d",
                     e.lst, e.pos, e.slot, e.n_before, e.n_after, e.n_long, e.last);
  endfunction

  // driver: item held until accepted, then the next one or an idle cycle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else if (!in_push || !in_full) begin
      if (in_push) begin
        if (cmd_on_bus.op == OP_FINISH) emit_lists();
        else file_reference(cmd_on_bus);
        items_taken <= items_taken + 1;
      end
      if (picture_cmds.size() != 0 && (calm || $urandom_range(0, 99) >= 19)) begin
        cmd_on_bus      = picture_cmds.pop_front();
        in_push         <= 1'b1;
        in_cmd          <= cmd_on_bus.op;
        in_short_before <= cmd_on_bus.st_before;
        in_short_after  <= cmd_on_bus.after;
        in_long_term    <= cmd_on_bus.long_term;
        in_ref_slot     <= cmd_on_bus.slot;
        in_ref_order    <= cmd_on_bus.order;
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    list_entry_t got;
    list_entry_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        got.lst      = list_id_t'(out_list_id);
        got.pos      = out_position;
        got.slot     = out_slot;
        got.n_before = out_count_before;
        got.n_after  = out_count_after;
        got.n_long   = out_count_long;
        got.last     = out_last;
        if (list_entries_due.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("unexpected item: %s", show_entry(got));
        end else begin
          want = list_entries_due.pop_front();
          if (got !== want) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: expected %s, got %s", show_entry(want), show_entry(got));
          end
        end
      end
      out_pop <= calm || ($urandom_range(0, 99) >= 19);
    end
  end

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= STALL_MAX);
    $display("** hevc_reference_list_builder_top: FAILED **");
    $finish;
  end

  initial begin
    int effective;
    int nadd;
    int r;
    ref_cmd_t c;

    for (int l = 0; l < NUM_LISTS; l++) list_fill[l] = 0;

    // directed opening
    queue_cmd(make_cmd(OP_FINISH, 1, 1, 1, 8'd254, 32'sh7FFF_FFFF));
    queue_cmd(make_cmd(OP_ADD, 0, 0, 0, 8'd7, 32'sd1));
    queue_cmd(make_cmd(OP_ADD, 1, 0, 0, 8'd0, 32'sd5));
    queue_cmd(make_cmd(OP_ADD, 1, 0, 0, 8'd254, 32'sh8000_0000));
    queue_cmd(make_cmd(OP_ADD, 1, 0, 0, 8'd3, 32'sh7FFF_FFFF));
    queue_cmd(make_cmd(OP_ADD, 1, 0, 0, 8'd9, 32'sd5));
    queue_cmd(make_cmd(OP_ADD, 1, 0, 0, 8'd0, 32'sd100));
    queue_cmd(make_cmd(OP_ADD, 1, 1, 1, 8'd10, 32'sd1));
    queue_cmd(make_cmd(OP_ADD, 0, 1, 1, 8'd11, -32'sd3));
    queue_cmd(make_cmd(OP_ADD, 0, 1, 0, 8'd12, -32'sd3));
    queue_cmd(make_cmd(OP_ADD, 0, 1, 0, 8'd13, 32'sh8000_0000));
    queue_cmd(make_cmd(OP_ADD, 0, 0, 1, 8'd255, 32'sh7FFF_FFFF));
    // overfill the long-term list
    for (int i = 0; i < 9; i++)
      queue_cmd(make_cmd(OP_ADD, 0, 0, 1, 8'(20 + i), pick_order()));
    queue_cmd(make_cmd(OP_FINISH, 0, 0, 0, 8'd0, 32'sd0));
    queue_cmd(make_cmd(OP_FINISH, 0, 1, 0, 8'd128, -32'sd1));

    // random pictures, each a run of adds closed by a finish
    effective = 0;
    while (effective < RAND_ITEMS) begin
      nadd = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 9);
      for (int k = 0; k < nadd; k++) begin
        c = make_cmd(OP_ADD, 0, 0, 0, pick_slot(), pick_order());
        r = $urandom_range(0, 9);
        if (r < 8) begin
          case ($urandom_range(0, 2))
            0: c.st_before = 1'b1;
            1: c.after = 1'b1;
            default: c.long_term = 1'b1;
          endcase
        end else begin
          {c.st_before, c.after, c.long_term} = 3'($urandom_range(0, 7));
        end
        queue_cmd(c);
        if (c.st_before || c.after || c.long_term) effective++;
      end
      c = make_cmd(OP_FINISH, 1'($urandom), 1'($urandom), 1'($urandom),
                   8'($urandom), $urandom);
      queue_cmd(c);
      effective++;
    end

    rst_n <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (picture_cmds.size() != 0 || in_push) @(posedge clk);
    while (list_entries_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (mismatches == 0)
      $display("** hevc_reference_list_builder_top: PASSED **");
    else
      $display("** hevc_reference_list_builder_top: FAILED **");
    $finish;
  end

endmodule
